// File: rtl/mt19937_pkg.sv
// Types, constants and tempering function shared by the MT19937 generator.
`timescale 1ns / 1ps
package mt19937_pkg;

	localparam logic [31:0] INIT_MULT = 32'd1812433253;
	localparam logic [31:0] TWIST_XOR = 32'h9908b0df;
	localparam logic [31:0] TEMPER_B  = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C  = 32'hefc60000;

	typedef enum logic {
		CMD_SEED = 1'b0,
		CMD_NEXT = 1'b1
	} command_t;

	typedef struct packed {
		command_t    command;
		logic [31:0] seed_value;
	} req_t;

	typedef struct packed {
		logic [31:0] random_word;
		logic [4:0]  top_bits;
	} rsp_t;

	function automatic logic [31:0] temper(input logic [31:0] v);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		a = v ^ (v >> 11);
		b = a ^ ((a << 7) & TEMPER_B);
		c = b ^ ((b << 15) & TEMPER_C);
		return c ^ (c >> 18);
	endfunction

endpackage

// File: rtl/mt19937_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mt19937_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/mt19937_generator_top.sv
// Top level of the MT19937 generator: pool memory, command sequencer, output register.
`timescale 1ns / 1ps
// A seed transaction fills the 624-word pool with the standard initialisation and
// produces no result; it writes one memory word on acceptance, then passes through a
// multiply state and an add-and-write state for each further word, the recurrence
// being serial through the multiplier. A next transaction passes through states
// ST_NX_Q, ST_NX_T and ST_NX_W, and its result is registered on leaving ST_NX_W: the pool
// memory has one read port and the twist needs three words (current, following and
// tap), read on consecutive cycles. ST_NX_W is extended while a previous word still
// waits stalled in the result register. req_stall is high while a transaction is in
// progress. A next transaction before any seed passes through the same states
// without a result.
// The result register lets a new transaction start while the previous word waits.
module mt19937_generator_top
	import mt19937_pkg::*;
#(
	parameter int POOL_WORDS = 624,
	parameter int TAP_OFFSET = 397
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int ADDR_W = $clog2(POOL_WORDS);
	localparam logic [ADDR_W:0]   POOL_N   = (ADDR_W + 1)'(POOL_WORDS);
	localparam logic [ADDR_W:0]   TAP_N    = (ADDR_W + 1)'(TAP_OFFSET);
	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(POOL_WORDS - 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_NX_Q   = 6'b000010,
		ST_NX_T   = 6'b000100,
		ST_NX_W   = 6'b001000,
		ST_SD_MUL = 6'b010000,
		ST_SD_ADD = 6'b100000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] pos_q;
	logic              seeded_q;
	logic [ADDR_W-1:0] idx_q;
	logic [31:0]       x_q;
	logic [31:0]       prod_q;
	logic [31:0]       hi_q;
	logic [31:0]       lo_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              accept;
	logic [ADDR_W-1:0] pos_next;
	logic [ADDR_W:0]   tap_sum;
	logic [ADDR_W-1:0] tap_idx;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [31:0]       ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [31:0]       ram_rdata;
	logic [31:0]       mix;
	logic [31:0]       twisted;
	logic [31:0]       tempered;
	logic [31:0]       seed_word;
	logic              out_free;
	logic              nx_done;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign pos_next  = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
	assign tap_sum   = {1'b0, pos_q} + TAP_N;
	assign tap_idx   = (tap_sum >= POOL_N) ? ADDR_W'(tap_sum - POOL_N) : tap_sum[ADDR_W-1:0];

	assign mix       = {hi_q[31], lo_q[30:0]};
	assign twisted   = ram_rdata ^ (mix >> 1) ^ (mix[0] ? TWIST_XOR : 32'd0);
	assign tempered  = temper(twisted);
	assign seed_word = prod_q + 32'(idx_q);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign nx_done   = (state_q == ST_NX_W) && (!seeded_q || out_free);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = twisted;
		ram_raddr = pos_q;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = pos_q;
				if (accept && req.command == CMD_SEED) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = req.seed_value;
				end
			end
			ST_NX_Q: ram_raddr = pos_next;
			ST_NX_T: ram_raddr = tap_idx;
			ST_NX_W: begin
				ram_raddr = tap_idx;
				ram_we    = nx_done && seeded_q;
			end
			ST_SD_ADD: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = seed_word;
			end
			default: ram_raddr = pos_q;
		endcase
	end

	mt19937_ram #(
		.WIDTH(32),
		.DEPTH(POOL_WORDS)
	) u_pool (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			seeded_q    <= 1'b0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.command == CMD_SEED) begin
							idx_q   <= ADDR_W'(1);
							state_q <= ST_SD_MUL;
						end else begin
							state_q <= ST_NX_Q;
						end
					end
				end
				ST_NX_Q: state_q <= ST_NX_T;
				ST_NX_T: state_q <= ST_NX_W;
				ST_NX_W: begin
					if (nx_done) begin
						if (seeded_q) begin
							rsp_valid_q <= 1'b1;
							pos_q       <= pos_next;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SD_MUL: state_q <= ST_SD_ADD;
				ST_SD_ADD: begin
					if (idx_q == LAST_IDX) begin
						pos_q    <= '0;
						seeded_q <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SD_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			x_q <= req.seed_value;
		end
		if (state_q == ST_SD_MUL) begin
			prod_q <= INIT_MULT * (x_q ^ (x_q >> 30));
		end
		if (state_q == ST_SD_ADD) begin
			x_q <= seed_word;
		end
		if (state_q == ST_NX_Q) begin
			hi_q <= ram_rdata;
		end
		if (state_q == ST_NX_T) begin
			lo_q <= ram_rdata;
		end
		if (nx_done && seeded_q) begin
			rsp_q.random_word <= tempered;
			rsp_q.top_bits    <= tempered[31:27];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/mt19937_checker.sv
// Port-level assertions for the MT19937 generator, bound to the top level.
`timescale 1ns / 1ps
module mt19937_port_checks
	import mt19937_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("stalled result changed");

	a_top_bits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.top_bits == rsp.random_word[31:27])
		else $error("top_bits disagree with random_word");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("transaction accepted on consecutive cycles");

endmodule

bind mt19937_generator_top mt19937_port_checks u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// File: tb/sv/mt19937_checker.sv
// Checker for the MT19937 generator: tracks the pool and compares every result word.
`timescale 1ns / 1ps
module mt19937_checker
	import mt19937_pkg::*;
#(
	parameter int POOL_WORDS = 624,
	parameter int TAP_OFFSET = 397
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   mismatches,
	output int   outstanding
);

	localparam logic [31:0] SEED_MULT  = 32'd1812433253;
	localparam logic [31:0] TWIST_MASK = 32'h9908b0df;
	localparam logic [31:0] SHAPE_B    = 32'h9d2c5680;
	localparam logic [31:0] SHAPE_C    = 32'hefc60000;

	logic [31:0] pool_copy [POOL_WORDS];
	int          word_pos;
	bit          seeded;
	rsp_t        expected_words [$];

	function automatic logic [31:0] shape_word(input logic [31:0] v);
		logic [31:0] t;
		t = v;
		t = t ^ (t >> 11);
		t = t ^ ((t << 7) & SHAPE_B);
		t = t ^ ((t << 15) & SHAPE_C);
		t = t ^ (t >> 18);
		return t;
	endfunction

	function automatic void reseed_pool(input logic [31:0] s);
		logic [31:0] prev;
		pool_copy[0] = s;
		for (int i = 1; i < POOL_WORDS; i++) begin
			prev = pool_copy[i - 1];
			pool_copy[i] = SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
		end
		word_pos = 0;
		seeded = 1'b1;
	endfunction

	function automatic rsp_t twist_next();
		int          nxt;
		int          tap;
		logic [31:0] mix;
		logic [31:0] w;
		rsp_t        r;
		nxt = (word_pos + 1) % POOL_WORDS;
		tap = (word_pos + TAP_OFFSET) % POOL_WORDS;
		mix = {pool_copy[word_pos][31], pool_copy[nxt][30:0]};
		w = pool_copy[tap] ^ (mix >> 1) ^ (mix[0] ? TWIST_MASK : 32'h0);
		pool_copy[word_pos] = w;
		word_pos = nxt;
		r.random_word = shape_word(w);
		r.top_bits = r.random_word[31:27];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			word_pos = 0;
			seeded = 1'b0;
			expected_words.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: expected no result, got word %08h top %02h", $time,
						rsp.random_word, rsp.top_bits);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (want.random_word !== rsp.random_word) begin
						$display("%0t: random_word expected %08h got %08h", $time,
							want.random_word, rsp.random_word);
						mismatches++;
					end
					if (want.top_bits !== rsp.top_bits) begin
						$display("%0t: top_bits expected %02h got %02h", $time,
							want.top_bits, rsp.top_bits);
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				if (req.command == CMD_SEED)
					reseed_pool(req.seed_value);
				else if (seeded)
					expected_words.insert(expected_words.size(), twist_next());
			end
		end
		outstanding = expected_words.size();
	end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the MT19937 generator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import mt19937_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int mismatches;
	int outstanding;
	int words_taken;
	bit quiet;

	mt19937_generator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	mt19937_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			words_taken <= words_taken + 1;
	end

	// Returns at the falling edge after the transaction is taken.
	task automatic send_item(input command_t c, input logic [31:0] s);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= '{command: c, seed_value: s};
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	initial begin : receiver
		int burst;
		bit held;
		held = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && words_taken >= 200) begin
				// long hold-off so the result register fills and the input backs up
				held = 1'b1;
				rsp_stall <= 1'b1;
				for (int n = 0; n < 400; n++)
					@(negedge clk);
				rsp_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 12);
				rsp_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		quiet = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// next before any seed: swallowed
		send_item(CMD_NEXT, 32'h0000_0000);
		send_item(CMD_NEXT, 32'hffff_ffff);
		send_item(CMD_SEED, 32'h0000_0000);
		repeat (4) send_item(CMD_NEXT, $urandom());
		send_item(CMD_SEED, 32'hffff_ffff);
		repeat (3) send_item(CMD_NEXT, $urandom());
		send_item(CMD_SEED, 32'd5489);
		repeat (4) send_item(CMD_NEXT, $urandom());
		send_item(CMD_SEED, 32'h8000_0000);
		repeat (2) send_item(CMD_NEXT, $urandom());
		send_item(CMD_SEED, 32'h7fff_ffff);
		repeat (2) send_item(CMD_NEXT, $urandom());

		// long run past the pool end to wrap the position
		send_item(CMD_SEED, $urandom());
		repeat (700) send_item(CMD_NEXT, $urandom());

		for (int k = 0; k < 930; k++) begin
			if (k == 780)
				quiet = 1'b1;
			if ($urandom_range(0, 59) == 0)
				send_item(CMD_SEED, $urandom());
			else
				send_item(CMD_NEXT, $urandom());
		end
		req_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (1300) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
